>>> design/enumerated_value_index_map_top_assert.svh
// Assertion macros shared by the block's modules.
`ifndef ENUMERATED_VALUE_INDEX_MAP_TOP_ASSERT_SVH
`define ENUMERATED_VALUE_INDEX_MAP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EVIM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EVIM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/evim_pkg.sv
package evim_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int LEN_LIMIT       = 4;
    localparam int VAL_W           = 32;
    localparam int IDX_W           = 6;
    localparam int VB_W            = 4;
    localparam int ST_W            = 3;
    localparam int IN_TDATA_W      = 48;
    localparam int OUT_TDATA_W     = 48;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_INDEX  = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_ABSENT   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_RD,
        S_INS_CMP,
        S_LK_RD,
        S_LK_CMP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_M1,
        RD_INDEX
    } t_rd_src;

    typedef struct packed {
        t_action            action;
        logic signed [31:0] item_value;
        logic [IDX_W-1:0]   item_index;
        logic [VB_W-1:0]    value_bytes;
    } t_item;

    typedef struct packed {
        logic    load;
        logic    clr_count;
        logic    inc_count;
        logic    ptr_top;
        logic    ptr_zero;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    rd_en;
        t_rd_src rd_src;
        logic    wr_en;
        logic    wr_shift;
        logic    set_st;
        t_status st;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    too_long;
        logic    full;
        logic    idx_ok;
        logic    cnt_zero;
        logic    ptr_is_zero;
        logic    ptr_last;
        logic    gt;
        logic    lt;
        logic    eq;
        logic    out_free;
    } t_sts;

endpackage

>>> design/evim_ctrl.sv
module evim_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  evim_pkg::t_sts  i_sts,
    output evim_pkg::t_cmd  o_cmd
);

    `include "enumerated_value_index_map_top_assert.svh"

    evim_pkg::t_state r_state;
    evim_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evim_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            evim_pkg::S_IDLE: begin
                if (i_in_valid) n_state = evim_pkg::S_DISPATCH;
            end
            evim_pkg::S_DISPATCH: begin
                case (i_sts.action)
                    evim_pkg::ACT_INSERT: begin
                        n_state = i_sts.full ? evim_pkg::S_EMIT : evim_pkg::S_INS_RD;
                    end
                    evim_pkg::ACT_LOOKUP: begin
                        if (i_sts.too_long || i_sts.cnt_zero) begin
                            n_state = evim_pkg::S_EMIT;
                        end else begin
                            n_state = evim_pkg::S_LK_RD;
                        end
                    end
                    default: n_state = evim_pkg::S_EMIT;
                endcase
            end
            evim_pkg::S_INS_RD: begin
                n_state = i_sts.ptr_is_zero ? evim_pkg::S_EMIT : evim_pkg::S_INS_CMP;
            end
            evim_pkg::S_INS_CMP: begin
                n_state = i_sts.gt ? evim_pkg::S_INS_RD : evim_pkg::S_EMIT;
            end
            evim_pkg::S_LK_RD: begin
                n_state = evim_pkg::S_LK_CMP;
            end
            evim_pkg::S_LK_CMP: begin
                if (i_sts.lt && !i_sts.ptr_last) begin
                    n_state = evim_pkg::S_LK_RD;
                end else begin
                    n_state = evim_pkg::S_EMIT;
                end
            end
            evim_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = evim_pkg::S_IDLE;
            end
            default: n_state = evim_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_src = evim_pkg::RD_PTR;
        o_cmd.st     = evim_pkg::ST_OK;
        o_in_ready   = 1'b0;
        case (r_state)
            evim_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            evim_pkg::S_DISPATCH: begin
                o_cmd.set_st = 1'b1;
                case (i_sts.action)
                    evim_pkg::ACT_CLEAR: begin
                        o_cmd.clr_count = 1'b1;
                    end
                    evim_pkg::ACT_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.st = evim_pkg::ST_FULL;
                        end else begin
                            o_cmd.ptr_top = 1'b1;
                        end
                    end
                    evim_pkg::ACT_LOOKUP: begin
                        if (i_sts.too_long) begin
                            o_cmd.st = evim_pkg::ST_TOO_LONG;
                        end else if (i_sts.cnt_zero) begin
                            o_cmd.st = evim_pkg::ST_ABSENT;
                        end else begin
                            o_cmd.ptr_zero = 1'b1;
                        end
                    end
                    evim_pkg::ACT_INDEX: begin
                        // Read now; data is registered by the time the result goes out.
                        if (i_sts.idx_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = evim_pkg::RD_INDEX;
                        end else begin
                            o_cmd.st = evim_pkg::ST_RANGE;
                        end
                    end
                    default: o_cmd.set_st = 1'b1;
                endcase
            end
            evim_pkg::S_INS_RD: begin
                if (i_sts.ptr_is_zero) begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.inc_count = 1'b1;
                    o_cmd.set_st    = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = evim_pkg::RD_PTR_M1;
                end
            end
            evim_pkg::S_INS_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_sts.gt) begin
                    // Move the greater entry up one slot and keep walking down.
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.ptr_dec  = 1'b1;
                end else begin
                    o_cmd.inc_count = 1'b1;
                    o_cmd.set_st    = 1'b1;
                end
            end
            evim_pkg::S_LK_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = evim_pkg::RD_PTR;
            end
            evim_pkg::S_LK_CMP: begin
                if (i_sts.lt && !i_sts.ptr_last) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = (!i_sts.lt && i_sts.eq) ? evim_pkg::ST_OK
                                                          : evim_pkg::ST_ABSENT;
                end
            end
            evim_pkg::S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    `EVIM_ASSERT_IMP(a_wr_only_insert, i_clk, i_rst_n, o_cmd.wr_en,
        (r_state == evim_pkg::S_INS_RD) || (r_state == evim_pkg::S_INS_CMP),
        "table write outside insert walk")
    `EVIM_ASSERT_IMP(a_emit_when_free, i_clk, i_rst_n, o_cmd.emit,
        (r_state == evim_pkg::S_EMIT) && i_sts.out_free,
        "result loaded while output register busy")
    `EVIM_ASSERT_NXT(a_accept_dispatch, i_clk, i_rst_n, o_in_ready && i_in_valid,
        r_state == evim_pkg::S_DISPATCH,
        "accepted item not dispatched")

endmodule

>>> design/evim_dp.sv
module evim_dp #(
    parameter int MAX_ENTRIES = evim_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  evim_pkg::t_item              i_item,
    input  evim_pkg::t_cmd               i_cmd,
    output evim_pkg::t_sts               o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [evim_pkg::IDX_W-1:0]   o_found_index,
    output logic signed [31:0]           o_found_value,
    output evim_pkg::t_status            o_status
);

    `include "enumerated_value_index_map_top_assert.svh"

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = CW + evim_pkg::IDX_W;

    evim_pkg::t_item     r_item;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_ptr;
    logic [CW-1:0]       n_ptr;
    evim_pkg::t_status   r_res_st;
    logic signed [31:0]  r_mem [MAX_ENTRIES];
    logic signed [31:0]  r_rd_data;
    logic                r_out_valid;
    logic [evim_pkg::IDX_W-1:0] r_found_index;
    logic signed [31:0]  r_found_value;
    evim_pkg::t_status   r_status;

    logic [CW-1:0]       ptr_m1;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic signed [31:0]  wr_data;
    logic [EW-1:0]       index_ext;
    logic [EW-1:0]       count_ext;
    logic [EW-1:0]       ptr_ext;
    logic [CW:0]         ptr_p1;
    logic                res_ok;

    assign ptr_m1    = r_ptr - CW'(1);
    assign index_ext = EW'(r_item.item_index);
    assign count_ext = EW'(r_count);
    assign ptr_ext   = EW'(r_ptr);
    assign ptr_p1    = (CW + 1)'(r_ptr) + (CW + 1)'(1);

    always_comb begin
        case (i_cmd.rd_src)
            evim_pkg::RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
            evim_pkg::RD_INDEX:  rd_addr = index_ext[AW-1:0];
            default:             rd_addr = r_ptr[AW-1:0];
        endcase
    end

    assign wr_addr = r_ptr[AW-1:0];
    assign wr_data = i_cmd.wr_shift ? r_rd_data : r_item.item_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_count) begin
            n_count = '0;
        end else if (i_cmd.inc_count) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_top) begin
            n_ptr = r_count;
        end else if (i_cmd.ptr_zero) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_dec) begin
            n_ptr = ptr_m1;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = ptr_p1[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign res_ok = (r_res_st == evim_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.set_st) r_res_st <= i_cmd.st;
        if (i_cmd.emit) begin
            r_status      <= r_res_st;
            r_found_index <= (res_ok && r_item.action == evim_pkg::ACT_LOOKUP)
                             ? ptr_ext[evim_pkg::IDX_W-1:0] : '0;
            r_found_value <= (res_ok && r_item.action == evim_pkg::ACT_INDEX)
                             ? r_rd_data : '0;
        end
    end

    always_comb begin
        o_sts.action      = r_item.action;
        o_sts.too_long    = r_item.value_bytes > evim_pkg::VB_W'(evim_pkg::LEN_LIMIT);
        o_sts.full        = r_count >= CW'(MAX_ENTRIES);
        o_sts.idx_ok      = index_ext < count_ext;
        o_sts.cnt_zero    = r_count == '0;
        o_sts.ptr_is_zero = r_ptr == '0;
        o_sts.ptr_last    = ptr_p1 >= (CW + 1)'(r_count);
        o_sts.gt          = r_rd_data > r_item.item_value;
        o_sts.lt          = r_rd_data < r_item.item_value;
        o_sts.eq          = r_rd_data == r_item.item_value;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found_index = r_found_index;
    assign o_found_value = r_found_value;
    assign o_status      = r_status;

    `EVIM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(MAX_ENTRIES), "entry count beyond table size")
    `EVIM_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit,
        r_out_valid, "loaded result not presented")
    `EVIM_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        r_out_valid && (r_status != evim_pkg::ST_OK),
        (r_found_index == '0) && (r_found_value == '0),
        "error result carries nonzero payload")

endmodule

>>> design/enumerated_value_index_map_top.sv
// Enumerated value / position map.
// Input stream (s_axis): one item per operation; tdata carries action, item_value,
// item_index and value_bytes. Output stream (m_axis): exactly one result per item;
// tdata carries found_index, found_value and status.
// Operations: clear the table, insert a value in ascending signed order (equal
// values go after existing ones), value to index (position of first equal
// entry), index to value.
// Flow: one item is worked at a time. Clear, index-to-value and any early
// error go straight to the result. Insert walks down from the top entry past
// every entry greater than the value; value-to-index walks up from entry zero
// to the stop position. Each step of those walks is one read of the table
// memory and one compare against its registered read data. The next item is
// accepted in the cycle after its result is loaded.
// The result sits in an output register: a new item is accepted while it waits,
// and a stalled receiver only holds the next result back from going out.
// Reset empties the table (entry count to zero) and drops any pending result;
// table contents are not cleared and are never read before being written.
module enumerated_value_index_map_top #(
    parameter int MAX_ENTRIES = evim_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [1:0] action, [33:2] item_value, [39:34] item_index, [43:40] value_bytes
    input  logic [evim_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [5:0] found_index, [37:6] found_value, [40:38] status
    output logic [evim_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    evim_pkg::t_item   in_item;
    evim_pkg::t_cmd    cmd;
    evim_pkg::t_sts    sts;
    logic [evim_pkg::IDX_W-1:0] found_index;
    logic signed [31:0] found_value;
    evim_pkg::t_status status;

    assign in_item.action      = evim_pkg::t_action'(i_s_axis_tdata[1:0]);
    assign in_item.item_value  = i_s_axis_tdata[33:2];
    assign in_item.item_index  = i_s_axis_tdata[39:34];
    assign in_item.value_bytes = i_s_axis_tdata[43:40];

    evim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    evim_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (in_item),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_found_index (found_index),
        .o_found_value (found_value),
        .o_status      (status)
    );

    assign o_m_axis_tdata = {7'b0, status, found_value, found_index};

endmodule
